@@ sv/wcd_pkg.sv @@
// Shared types, codes and sample conversion functions of the WAV container decoder.
`timescale 1ns / 1ps

package wcd_pkg;

  // Request opcodes.
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_PARSE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  // Status codes. A parse checks them in the listed order, but ST_OVERFLOW first; ST_RANGE comes from reads.
  localparam logic [3:0] ST_OK       = 4'd0;
  localparam logic [3:0] ST_SMALL    = 4'd1;
  localparam logic [3:0] ST_RIFF     = 4'd2;
  localparam logic [3:0] ST_WAVE     = 4'd3;
  localparam logic [3:0] ST_FMT      = 4'd4;
  localparam logic [3:0] ST_EXT      = 4'd5;
  localparam logic [3:0] ST_NOFMT    = 4'd6;
  localparam logic [3:0] ST_NODATA   = 4'd7;
  localparam logic [3:0] ST_TAG      = 4'd8;
  localparam logic [3:0] ST_CH       = 4'd9;
  localparam logic [3:0] ST_RATE     = 4'd10;
  localparam logic [3:0] ST_DEPTH0   = 4'd11;
  localparam logic [3:0] ST_FDEPTH   = 4'd12;
  localparam logic [3:0] ST_PDEPTH   = 4'd13;
  localparam logic [3:0] ST_RANGE    = 4'd14;
  localparam logic [3:0] ST_OVERFLOW = 4'd15;

  // Chunk identifiers as little-endian words.
  localparam logic [31:0] ID_RIFF = 32'h4646_4952;
  localparam logic [31:0] ID_WAVE = 32'h4556_4157;
  localparam logic [31:0] ID_FMT  = 32'h2074_6D66;
  localparam logic [31:0] ID_DATA = 32'h6174_6164;

  // Format tags.
  localparam logic [15:0] TAG_PCM   = 16'h0001;
  localparam logic [15:0] TAG_FLOAT = 16'h0003;
  localparam logic [15:0] TAG_EXT   = 16'hFFFE;

  // Widths of the offset walker, the divider and the sample sum.
  localparam int unsigned OW  = 34;
  localparam int unsigned DW  = 48;
  localparam int unsigned VW  = 32;
  localparam int unsigned FBW = 29;

  typedef enum logic [4:0] {
    S_IDLE, S_FETCH_RD, S_FETCH_WT,
    S_P_START, S_P_RIFF, S_P_WAVE, S_P_LOOP, S_P_CHUNK,
    S_P_FMT1, S_P_FMT2, S_P_FMT3, S_P_END, S_P_DIV, S_P_DWAIT,
    S_R_MUL, S_R_BASE, S_R_NEXT, S_R_CONV, S_R_ACC, S_R_DIV, S_R_DWAIT,
    S_DONE
  } state_e;

  // Integer PCM sample to signed Q0.31.
  function automatic logic [31:0] pcm_to_q31(logic [63:0] w, logic [15:0] bits);
    logic [31:0] r;
    case (bits)
      16'd8:   r = {~w[7], w[6:0], 24'h000000};
      16'd16:  r = {w[15:0], 16'h0000};
      16'd24:  r = {w[23:0], 8'h00};
      default: r = w[31:0];
    endcase
    return r;
  endfunction

  // IEEE float (32 or 64 bit) to signed Q0.31, truncated toward zero and saturated.
  function automatic logic [31:0] float_to_q31(logic [63:0] w, logic is64);
    logic [10:0]        e;
    logic               neg;
    logic               emax;
    logic               fnz;
    logic [52:0]        m;
    logic signed [12:0] k;
    logic [12:0]        nk;
    logic [63:0]        v;
    logic [31:0]        r;
    if (is64) begin
      e    = w[62:52];
      neg  = w[63];
      emax = (e == 11'h7FF);
      fnz  = (w[51:0] != 52'd0);
      m    = {(e != 11'd0), w[51:0]};
      k    = $signed({2'b00, ((e != 11'd0) ? e : 11'd1)}) - 13'sd1044;
    end else begin
      e    = {3'b000, w[30:23]};
      neg  = w[31];
      emax = (w[30:23] == 8'hFF);
      fnz  = (w[22:0] != 23'd0);
      m    = {29'd0, (e != 11'd0), w[22:0]};
      k    = $signed({2'b00, ((e != 11'd0) ? e : 11'd1)}) - 13'sd119;
    end
    nk = 13'(-k);
    if (k >= 13'sd11) begin
      v = 64'h1_0000_0000;
    end else if (k >= 13'sd0) begin
      v = {11'd0, m} << k[3:0];
    end else if (nk < 13'd64) begin
      v = {11'd0, m} >> nk[5:0];
    end else begin
      v = 64'd0;
    end
    if (emax) begin
      r = fnz ? 32'h0000_0000 : (neg ? 32'h8000_0000 : 32'h7FFF_FFFF);
    end else if (neg) begin
      r = (v >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-v);
    end else begin
      r = (v > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : v[31:0];
    end
    return r;
  endfunction

endpackage

@@ sv/wcd_div.sv @@
// Shared radix-2 restoring divider of the WAV container decoder, one quotient bit a cycle.
`timescale 1ns / 1ps

module wcd_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [wcd_pkg::DW-1:0]    dividend_i,
  input  logic [wcd_pkg::VW-1:0]    divisor_i,
  output logic                      done_o,
  output logic [wcd_pkg::DW-1:0]    quotient_o
);

  localparam int unsigned CW = $clog2(wcd_pkg::DW + 1);

  logic                      busy_q, busy_d;
  logic                      done_q, done_d;
  logic [CW-1:0]             cnt_q, cnt_d;
  logic [wcd_pkg::VW-1:0]    rem_q, rem_d;
  logic [wcd_pkg::VW-1:0]    dvs_q, dvs_d;
  logic [wcd_pkg::DW-1:0]    quo_q, quo_d;
  logic [wcd_pkg::VW:0]      trial;
  logic                      fits;

  // One shift-and-subtract step per cycle.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    trial  = {rem_q, quo_q[wcd_pkg::DW-1]};
    fits   = (trial >= {1'b0, dvs_q});
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(wcd_pkg::DW);
      rem_d  = '0;
      dvs_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = fits ? wcd_pkg::VW'(trial - {1'b0, dvs_q}) : trial[wcd_pkg::VW-1:0];
      quo_d = {quo_q[wcd_pkg::DW-2:0], fits};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

@@ sv/wav_container_decoder_unit.sv @@
// Top level of the WAV container decoder: file memory, chunk walker and frame reader.
`timescale 1ns / 1ps

// A load request writes one byte into the file memory, or sets the overflow flag once
// the memory is full; neither a load nor a clear gives a result. All parsing and frame
// reading goes through the single read port of the file memory, which yields one byte
// per read and wait state pair. A parse checks the header, walks the chunk headers,
// reads each fmt chunk, then divides the data length by the frame size for the frame
// count. A frame read fetches and converts the sample of each channel, then divides the
// channel sum by the channel count. The memory has no clearing pass: a clear resets
// only the fill count, the overflow flag and the held parse. A result waits in the
// output register while the next request is taken.
module wav_container_decoder_unit #(
  parameter int unsigned STORE_BYTES = 65536
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         opcode_i,
  input  logic [7:0]         data_byte_i,
  input  logic [15:0]        frame_index_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [3:0]         status_o,
  output logic signed [23:0] mono_sample_o,
  output logic [31:0]        sample_rate_o,
  output logic [16:0]        frame_count_o,
  output logic [15:0]        channel_count_o,
  output logic [15:0]        bits_per_sample_o
);

  localparam int unsigned AW  = $clog2(STORE_BYTES);
  localparam int unsigned LW  = $clog2(STORE_BYTES + 1);
  localparam int unsigned OW  = wcd_pkg::OW;
  localparam int unsigned DW  = wcd_pkg::DW;
  localparam int unsigned VW  = wcd_pkg::VW;
  localparam int unsigned FBW = wcd_pkg::FBW;

  // File memory.
  logic [7:0]    mem_q [STORE_BYTES];
  logic [7:0]    mem_rdata_q;
  logic          wr_en;
  logic          rd_en;
  logic [AW-1:0] rd_addr;

  // Sequencer and fetch unit.
  wcd_pkg::state_e state_q, state_d, ret_q, ret_d;
  logic [OW-1:0] fetch_addr_q, fetch_addr_d;
  logic [3:0]    fetch_n_q, fetch_n_d;
  logic [2:0]    fetch_cnt_q, fetch_cnt_d;
  logic [63:0]   acc_q, acc_d;

  // File state and held parse results.
  logic [LW-1:0] len_q, len_d;
  logic          ovf_q, ovf_d;
  logic          parse_done_q, parse_done_d;
  logic [3:0]    parse_status_q, parse_status_d;
  logic [15:0]   tag_h_q, tag_h_d;
  logic [15:0]   ch_h_q, ch_h_d;
  logic [31:0]   rate_h_q, rate_h_d;
  logic [15:0]   bits_h_q, bits_h_d;
  logic [LW-1:0] dstart_h_q, dstart_h_d;
  logic [16:0]   frames_h_q, frames_h_d;
  logic [FBW-1:0] fbytes_h_q, fbytes_h_d;

  // Working registers of the current request.
  logic [1:0]    op_q, op_d;
  logic [15:0]   idx_q, idx_d;
  logic [OW-1:0] off_q, off_d;
  logic [31:0]   size_q, size_d;
  logic [15:0]   t_tag_q, t_tag_d;
  logic [15:0]   t_ch_q, t_ch_d;
  logic [31:0]   t_rate_q, t_rate_d;
  logic [15:0]   t_bits_q, t_bits_d;
  logic          have_fmt_q, have_fmt_d;
  logic          have_data_q, have_data_d;
  logic [LW-1:0] d_off_q, d_off_d;
  logic [LW-1:0] d_len_q, d_len_d;
  logic [FBW-1:0] fb_q, fb_d;
  logic [44:0]   prod_q, prod_d;
  logic [31:0]   samp_q, samp_d;
  logic [DW-1:0] sum_q, sum_d;
  logic [15:0]   chan_left_q, chan_left_d;
  logic [3:0]    res_status_q, res_status_d;
  logic [23:0]   mono_q, mono_d;

  // Output register.
  logic          out_valid_q, out_valid_d;
  logic [3:0]    out_status_q, out_status_d;
  logic [23:0]   out_mono_q, out_mono_d;
  logic [31:0]   out_rate_q, out_rate_d;
  logic [16:0]   out_frames_q, out_frames_d;
  logic [15:0]   out_ch_q, out_ch_d;
  logic [15:0]   out_bits_q, out_bits_d;

  // Divider.
  logic          div_start;
  logic [DW-1:0] div_a;
  logic [VW-1:0] div_b;
  logic          div_done;
  logic [DW-1:0] div_quo;

  // Helpers.
  logic          fetch_go;
  logic [OW-1:0] fetch_at;
  logic [3:0]    fetch_len;
  wcd_pkg::state_e fetch_ret;
  logic          fin_go;
  logic [3:0]    fin_status;
  logic [OW-1:0] len_w;
  logic [OW-1:0] pay;
  logic [31:0]   chunk_size;
  logic [OW-1:0] next_off;
  logic [12:0]   bps;
  logic [DW-1:0] sum_mag;

  assign len_w      = OW'(len_q);
  assign pay        = off_q + OW'(8);
  assign chunk_size = (state_q == wcd_pkg::S_P_CHUNK) ? acc_q[63:32] : size_q;
  assign next_off   = off_q + OW'(8) + OW'(chunk_size) + OW'(chunk_size[0]);
  assign bps        = t_bits_q[15:3];
  assign sum_mag    = sum_q[DW-1] ? DW'(-sum_q) : sum_q;

  assign div_a = (state_q == wcd_pkg::S_R_DIV) ? sum_mag : DW'(d_len_q);
  assign div_b = (state_q == wcd_pkg::S_R_DIV) ? VW'({ch_h_q, 8'h00}) : VW'(fb_q);

  wcd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Memory: one write port for loads, one registered read port for the fetch unit.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[len_q[AW-1:0]] <= data_byte_i;
    end
    if (rd_en) begin
      mem_rdata_q <= mem_q[rd_addr];
    end
  end

  assign rd_addr = AW'(fetch_addr_q + OW'(fetch_cnt_q));

  // Sequencer: request decode, chunk walk, frame read and result hand-off.
  always_comb begin
    state_d        = state_q;
    ret_d          = ret_q;
    fetch_addr_d   = fetch_addr_q;
    fetch_n_d      = fetch_n_q;
    fetch_cnt_d    = fetch_cnt_q;
    acc_d          = acc_q;
    len_d          = len_q;
    ovf_d          = ovf_q;
    parse_done_d   = parse_done_q;
    parse_status_d = parse_status_q;
    tag_h_d        = tag_h_q;
    ch_h_d         = ch_h_q;
    rate_h_d       = rate_h_q;
    bits_h_d       = bits_h_q;
    dstart_h_d     = dstart_h_q;
    frames_h_d     = frames_h_q;
    fbytes_h_d     = fbytes_h_q;
    op_d           = op_q;
    idx_d          = idx_q;
    off_d          = off_q;
    size_d         = size_q;
    t_tag_d        = t_tag_q;
    t_ch_d         = t_ch_q;
    t_rate_d       = t_rate_q;
    t_bits_d       = t_bits_q;
    have_fmt_d     = have_fmt_q;
    have_data_d    = have_data_q;
    d_off_d        = d_off_q;
    d_len_d        = d_len_q;
    fb_d           = fb_q;
    prod_d         = prod_q;
    samp_d         = samp_q;
    sum_d          = sum_q;
    chan_left_d    = chan_left_q;
    res_status_d   = res_status_q;
    mono_d         = mono_q;
    out_valid_d    = out_valid_q;
    out_status_d   = out_status_q;
    out_mono_d     = out_mono_q;
    out_rate_d     = out_rate_q;
    out_frames_d   = out_frames_q;
    out_ch_d       = out_ch_q;
    out_bits_d     = out_bits_q;
    wr_en          = 1'b0;
    rd_en          = 1'b0;
    div_start      = 1'b0;
    fetch_go       = 1'b0;
    fetch_at       = '0;
    fetch_len      = 4'd0;
    fetch_ret      = wcd_pkg::S_IDLE;
    fin_go         = 1'b0;
    fin_status     = wcd_pkg::ST_OK;
    in_ready_o     = (state_q == wcd_pkg::S_IDLE);

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      wcd_pkg::S_IDLE: begin
        if (in_valid_i) begin
          op_d   = opcode_i;
          idx_d  = frame_index_i;
          mono_d = '0;
          if (opcode_i != wcd_pkg::OP_READ) begin
            // Loads, clears and parses all drop the held parse.
            parse_done_d   = 1'b0;
            parse_status_d = wcd_pkg::ST_OK;
            tag_h_d        = '0;
            ch_h_d         = '0;
            rate_h_d       = '0;
            bits_h_d       = '0;
            dstart_h_d     = '0;
            frames_h_d     = '0;
            fbytes_h_d     = '0;
          end
          case (opcode_i)
            wcd_pkg::OP_LOAD: begin
              if (len_q < LW'(STORE_BYTES)) begin
                wr_en = 1'b1;
                len_d = len_q + LW'(1);
              end else begin
                ovf_d = 1'b1;
              end
            end
            wcd_pkg::OP_CLEAR: begin
              len_d = '0;
              ovf_d = 1'b0;
            end
            wcd_pkg::OP_PARSE: begin
              state_d = wcd_pkg::S_P_START;
            end
            default: begin
              if (parse_done_q && (parse_status_q != wcd_pkg::ST_OK)) begin
                fin_go     = 1'b1;
                fin_status = parse_status_q;
              end else if (!parse_done_q || ({1'b0, frame_index_i} >= frames_h_q)) begin
                fin_go     = 1'b1;
                fin_status = wcd_pkg::ST_RANGE;
              end else begin
                state_d = wcd_pkg::S_R_MUL;
              end
            end
          endcase
        end
      end

      // Fetch unit: little-endian gather of up to eight bytes into acc_q.
      wcd_pkg::S_FETCH_RD: begin
        rd_en   = 1'b1;
        state_d = wcd_pkg::S_FETCH_WT;
      end
      wcd_pkg::S_FETCH_WT: begin
        acc_d[{fetch_cnt_q, 3'b000} +: 8] = mem_rdata_q;
        if ({1'b0, fetch_cnt_q} == fetch_n_q - 4'd1) begin
          state_d = ret_q;
        end else begin
          fetch_cnt_d = fetch_cnt_q + 3'd1;
          state_d     = wcd_pkg::S_FETCH_RD;
        end
      end

      // Header checks.
      wcd_pkg::S_P_START: begin
        if (ovf_q) begin
          fin_go     = 1'b1;
          fin_status = wcd_pkg::ST_OVERFLOW;
        end else if (len_q < LW'(12)) begin
          fin_go     = 1'b1;
          fin_status = wcd_pkg::ST_SMALL;
        end else begin
          fetch_go  = 1'b1;
          fetch_at  = '0;
          fetch_len = 4'd4;
          fetch_ret = wcd_pkg::S_P_RIFF;
        end
      end
      wcd_pkg::S_P_RIFF: begin
        if (acc_q[31:0] != wcd_pkg::ID_RIFF) begin
          fin_go     = 1'b1;
          fin_status = wcd_pkg::ST_RIFF;
        end else begin
          fetch_go  = 1'b1;
          fetch_at  = OW'(8);
          fetch_len = 4'd4;
          fetch_ret = wcd_pkg::S_P_WAVE;
        end
      end
      wcd_pkg::S_P_WAVE: begin
        if (acc_q[31:0] != wcd_pkg::ID_WAVE) begin
          fin_go     = 1'b1;
          fin_status = wcd_pkg::ST_WAVE;
        end else begin
          off_d       = OW'(12);
          have_fmt_d  = 1'b0;
          have_data_d = 1'b0;
          state_d     = wcd_pkg::S_P_LOOP;
        end
      end

      // Chunk walk.
      wcd_pkg::S_P_LOOP: begin
        if (pay <= len_w) begin
          fetch_go  = 1'b1;
          fetch_at  = off_q;
          fetch_len = 4'd8;
          fetch_ret = wcd_pkg::S_P_CHUNK;
        end else begin
          state_d = wcd_pkg::S_P_END;
        end
      end
      wcd_pkg::S_P_CHUNK: begin
        size_d = acc_q[63:32];
        if (acc_q[31:0] == wcd_pkg::ID_FMT) begin
          if ((acc_q[63:32] < 32'd16) || (pay + OW'(16) > len_w)) begin
            fin_go     = 1'b1;
            fin_status = wcd_pkg::ST_FMT;
          end else begin
            fetch_go  = 1'b1;
            fetch_at  = pay;
            fetch_len = 4'd8;
            fetch_ret = wcd_pkg::S_P_FMT1;
          end
        end else begin
          if (acc_q[31:0] == wcd_pkg::ID_DATA) begin
            d_off_d     = LW'(pay);
            d_len_d     = (pay + OW'(acc_q[63:32]) > len_w) ? LW'(len_w - pay)
                                                           : LW'(acc_q[63:32]);
            have_data_d = 1'b1;
          end
          off_d   = next_off;
          state_d = wcd_pkg::S_P_LOOP;
        end
      end
      wcd_pkg::S_P_FMT1: begin
        t_tag_d   = acc_q[15:0];
        t_ch_d    = acc_q[31:16];
        t_rate_d  = acc_q[63:32];
        fetch_go  = 1'b1;
        fetch_at  = pay + OW'(14);
        fetch_len = 4'd2;
        fetch_ret = wcd_pkg::S_P_FMT2;
      end
      wcd_pkg::S_P_FMT2: begin
        t_bits_d = acc_q[15:0];
        if (t_tag_q == wcd_pkg::TAG_EXT) begin
          if ((size_q < 32'd40) || (pay + OW'(26) > len_w)) begin
            fin_go     = 1'b1;
            fin_status = wcd_pkg::ST_EXT;
          end else begin
            fetch_go  = 1'b1;
            fetch_at  = pay + OW'(24);
            fetch_len = 4'd2;
            fetch_ret = wcd_pkg::S_P_FMT3;
          end
        end else begin
          have_fmt_d = 1'b1;
          off_d      = next_off;
          state_d    = wcd_pkg::S_P_LOOP;
        end
      end
      wcd_pkg::S_P_FMT3: begin
        t_tag_d    = acc_q[15:0];
        have_fmt_d = 1'b1;
        off_d      = next_off;
        state_d    = wcd_pkg::S_P_LOOP;
      end

      // Final checks and frame count.
      wcd_pkg::S_P_END: begin
        fin_go = 1'b1;
        if (!have_fmt_q) begin
          fin_status = wcd_pkg::ST_NOFMT;
        end else if (!have_data_q) begin
          fin_status = wcd_pkg::ST_NODATA;
        end else if ((t_tag_q != wcd_pkg::TAG_PCM) && (t_tag_q != wcd_pkg::TAG_FLOAT)) begin
          fin_status = wcd_pkg::ST_TAG;
        end else if (t_ch_q == 16'd0) begin
          fin_status = wcd_pkg::ST_CH;
        end else if (t_rate_q == 32'd0) begin
          fin_status = wcd_pkg::ST_RATE;
        end else if (bps == 13'd0) begin
          fin_status = wcd_pkg::ST_DEPTH0;
        end else begin
          fin_go  = 1'b0;
          fb_d    = FBW'(bps * t_ch_q);
          state_d = wcd_pkg::S_P_DIV;
        end
      end
      wcd_pkg::S_P_DIV: begin
        div_start = 1'b1;
        state_d   = wcd_pkg::S_P_DWAIT;
      end
      wcd_pkg::S_P_DWAIT: begin
        if (div_done) begin
          fin_go = 1'b1;
          if ((div_quo != '0) && (t_tag_q == wcd_pkg::TAG_FLOAT) &&
              (t_bits_q != 16'd32) && (t_bits_q != 16'd64)) begin
            fin_status = wcd_pkg::ST_FDEPTH;
          end else if ((div_quo != '0) && (t_tag_q == wcd_pkg::TAG_PCM) &&
                       (t_bits_q != 16'd8) && (t_bits_q != 16'd16) &&
                       (t_bits_q != 16'd24) && (t_bits_q != 16'd32)) begin
            fin_status = wcd_pkg::ST_PDEPTH;
          end else begin
            fin_status = wcd_pkg::ST_OK;
            tag_h_d    = t_tag_q;
            ch_h_d     = t_ch_q;
            rate_h_d   = t_rate_q;
            bits_h_d   = t_bits_q;
            dstart_h_d = d_off_q;
            fbytes_h_d = fb_q;
            frames_h_d = (div_quo > DW'(17'h1FFFF)) ? 17'h1FFFF : div_quo[16:0];
          end
        end
      end

      // Frame read: base address, per-channel fetch and convert, then average.
      wcd_pkg::S_R_MUL: begin
        prod_d  = 45'(idx_q * fbytes_h_q);
        state_d = wcd_pkg::S_R_BASE;
      end
      wcd_pkg::S_R_BASE: begin
        off_d       = OW'(dstart_h_q) + prod_q[OW-1:0];
        chan_left_d = ch_h_q;
        sum_d       = '0;
        state_d     = wcd_pkg::S_R_NEXT;
      end
      wcd_pkg::S_R_NEXT: begin
        fetch_go  = 1'b1;
        fetch_at  = off_q;
        fetch_len = bits_h_q[6:3];
        fetch_ret = wcd_pkg::S_R_CONV;
      end
      wcd_pkg::S_R_CONV: begin
        samp_d  = (tag_h_q == wcd_pkg::TAG_FLOAT)
                  ? wcd_pkg::float_to_q31(acc_q, (bits_h_q == 16'd64))
                  : wcd_pkg::pcm_to_q31(acc_q, bits_h_q);
        state_d = wcd_pkg::S_R_ACC;
      end
      wcd_pkg::S_R_ACC: begin
        sum_d       = sum_q + {{(DW - 32){samp_q[31]}}, samp_q};
        off_d       = off_q + OW'(bits_h_q[6:3]);
        chan_left_d = chan_left_q - 16'd1;
        state_d     = (chan_left_q == 16'd1) ? wcd_pkg::S_R_DIV : wcd_pkg::S_R_NEXT;
      end
      wcd_pkg::S_R_DIV: begin
        div_start = 1'b1;
        state_d   = wcd_pkg::S_R_DWAIT;
      end
      wcd_pkg::S_R_DWAIT: begin
        if (div_done) begin
          fin_go     = 1'b1;
          fin_status = wcd_pkg::ST_OK;
          if (sum_q[DW-1]) begin
            mono_d = (div_quo[DW-1:23] != '0) ? 24'h800000 : 24'(-div_quo[23:0]);
          end else begin
            mono_d = (div_quo[DW-1:23] != '0) ? 24'h7FFFFF : div_quo[23:0];
          end
        end
      end

      // Hand the result to the output register once it is free.
      wcd_pkg::S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_mono_d   = mono_q;
          out_rate_d   = rate_h_q;
          out_frames_d = frames_h_q;
          out_ch_d     = ch_h_q;
          out_bits_d   = bits_h_q;
          if (op_q == wcd_pkg::OP_PARSE) begin
            parse_done_d   = 1'b1;
            parse_status_d = res_status_q;
          end
          state_d = wcd_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = wcd_pkg::S_IDLE;
      end
    endcase

    // Start a fetch and remember where to continue.
    if (fetch_go) begin
      fetch_addr_d = fetch_at;
      fetch_n_d    = fetch_len;
      fetch_cnt_d  = 3'd0;
      acc_d        = '0;
      ret_d        = fetch_ret;
      state_d      = wcd_pkg::S_FETCH_RD;
    end

    // Finish the request with a status.
    if (fin_go) begin
      res_status_d = fin_status;
      state_d      = wcd_pkg::S_DONE;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= wcd_pkg::S_IDLE;
      ret_q          <= wcd_pkg::S_IDLE;
      len_q          <= '0;
      ovf_q          <= 1'b0;
      parse_done_q   <= 1'b0;
      parse_status_q <= wcd_pkg::ST_OK;
      tag_h_q        <= '0;
      ch_h_q         <= '0;
      rate_h_q       <= '0;
      bits_h_q       <= '0;
      dstart_h_q     <= '0;
      frames_h_q     <= '0;
      fbytes_h_q     <= '0;
      out_valid_q    <= 1'b0;
      fetch_n_q      <= 4'd1;
      fetch_cnt_q    <= '0;
    end else begin
      state_q        <= state_d;
      ret_q          <= ret_d;
      len_q          <= len_d;
      ovf_q          <= ovf_d;
      parse_done_q   <= parse_done_d;
      parse_status_q <= parse_status_d;
      tag_h_q        <= tag_h_d;
      ch_h_q         <= ch_h_d;
      rate_h_q       <= rate_h_d;
      bits_h_q       <= bits_h_d;
      dstart_h_q     <= dstart_h_d;
      frames_h_q     <= frames_h_d;
      fbytes_h_q     <= fbytes_h_d;
      out_valid_q    <= out_valid_d;
      fetch_n_q      <= fetch_n_d;
      fetch_cnt_q    <= fetch_cnt_d;
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk_i) begin
    fetch_addr_q <= fetch_addr_d;
    acc_q        <= acc_d;
    op_q         <= op_d;
    idx_q        <= idx_d;
    off_q        <= off_d;
    size_q       <= size_d;
    t_tag_q      <= t_tag_d;
    t_ch_q       <= t_ch_d;
    t_rate_q     <= t_rate_d;
    t_bits_q     <= t_bits_d;
    have_fmt_q   <= have_fmt_d;
    have_data_q  <= have_data_d;
    d_off_q      <= d_off_d;
    d_len_q      <= d_len_d;
    fb_q         <= fb_d;
    prod_q       <= prod_d;
    samp_q       <= samp_d;
    sum_q        <= sum_d;
    chan_left_q  <= chan_left_d;
    res_status_q <= res_status_d;
    mono_q       <= mono_d;
    out_status_q <= out_status_d;
    out_mono_q   <= out_mono_d;
    out_rate_q   <= out_rate_d;
    out_frames_q <= out_frames_d;
    out_ch_q     <= out_ch_d;
    out_bits_q   <= out_bits_d;
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign mono_sample_o     = out_mono_q;
  assign sample_rate_o     = out_rate_q;
  assign frame_count_o     = out_frames_q;
  assign channel_count_o   = out_ch_q;
  assign bits_per_sample_o = out_bits_q;

  // A byte is only written below the memory size.
  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (len_q < LW'(STORE_BYTES)))
    else $error("file memory written beyond its size");

  // A frame read only runs on a successful parse.
  a_read_needs_parse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == wcd_pkg::S_R_MUL || state_q == wcd_pkg::S_R_ACC) |->
    (parse_done_q && parse_status_q == wcd_pkg::ST_OK))
    else $error("frame read without a successful parse");

  // The divider only finishes while the sequencer waits for it.
  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == wcd_pkg::S_P_DWAIT || state_q == wcd_pkg::S_R_DWAIT))
    else $error("division result not awaited");

  // A failed parse leaves no held values.
  a_failed_parse_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (parse_done_q && parse_status_q != wcd_pkg::ST_OK) |->
    (rate_h_q == 32'd0 && frames_h_q == 17'd0 && ch_h_q == 16'd0))
    else $error("held values survive a failed parse");

  // A fetch gathers between one and eight bytes.
  a_fetch_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == wcd_pkg::S_FETCH_RD) |-> (fetch_n_q != 4'd0 && fetch_n_q <= 4'd8))
    else $error("fetch length out of range");

endmodule

@@ bench/tb_wav_container_decoder_unit.sv @@
// Testbench of the WAV container decoder: directed and random files checked against a predictor.
`timescale 1ns / 1ps

module tb_wav_container_decoder_unit;
  import wcd_pkg::*;

  localparam int unsigned MEM_BYTES      = 65536;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned SETTLE_CYCLES  = 300;

  typedef struct {
    logic [3:0]         status;
    logic signed [23:0] mono;
    logic [31:0]        rate;
    logic [16:0]        frames;
    logic [15:0]        channels;
    logic [15:0]        bits;
  } decode_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         opcode = OP_CLEAR;
  logic [7:0]         data_byte = 8'd0;
  logic [15:0]        frame_index = 16'd0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [3:0]         status;
  logic signed [23:0] mono_sample;
  logic [31:0]        sample_rate;
  logic [16:0]        frame_count;
  logic [15:0]        channel_count;
  logic [15:0]        bits_per_sample;

  // Predictor state: the loaded file and what the last parse holds.
  logic [7:0]      file_mem [MEM_BYTES];
  int unsigned     fill_len = 0;
  bit              mem_full_seen = 1'b0;
  bit              parse_held = 1'b0;
  logic [3:0]      held_status = ST_OK;
  logic [15:0]     held_tag = 16'd0;
  logic [15:0]     held_ch = 16'd0;
  logic [31:0]     held_rate = 32'd0;
  logic [15:0]     held_bits = 16'd0;
  longint unsigned held_start = 0;
  logic [16:0]     held_frames = 17'd0;

  decode_result_t  pending_results[$];
  logic [7:0]      wav_bytes[$];
  int unsigned     mismatches = 0;
  int unsigned     quiet_cycles = 0;
  bit              idle_on = 1'b1;
  bit              stall_on = 1'b1;

  wav_container_decoder_unit u_top (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .opcode_i          (opcode),
    .data_byte_i       (data_byte),
    .frame_index_i     (frame_index),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .status_o          (status),
    .mono_sample_o     (mono_sample),
    .sample_rate_o     (sample_rate),
    .frame_count_o     (frame_count),
    .channel_count_o   (channel_count),
    .bits_per_sample_o (bits_per_sample)
  );

  // Clock.
  always #6 clk = ~clk;

  // Result side back-pressure.
  always @(posedge clk) begin
    out_ready <= !stall_on || ($urandom_range(99) >= 7);
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [7:0] mem_byte(longint unsigned i);
    return (i < fill_len) ? file_mem[i] : 8'h00;
  endfunction

  function automatic logic [31:0] mem_le(longint unsigned i, int n);
    logic [31:0] w;
    w = 32'd0;
    for (int k = 0; k < n; k++) w[8*k +: 8] = mem_byte(i + k);
    return w;
  endfunction

  function automatic bit has_id(longint unsigned i, logic [31:0] id);
    return (i + 4 <= fill_len) && (mem_le(i, 4) == id);
  endfunction

  function automatic void drop_parse();
    parse_held  = 1'b0;
    held_status = ST_OK;
    held_tag    = 16'd0;
    held_ch     = 16'd0;
    held_rate   = 32'd0;
    held_bits   = 16'd0;
    held_start  = 0;
    held_frames = 17'd0;
  endfunction

  // Walks the chunk table; on success the held format is updated.
  function automatic logic [3:0] walk_file();
    longint unsigned off, size, pay, d_off, d_len, frm;
    logic [15:0]     t, c, b;
    logic [31:0]     r;
    bit              got_fmt, got_data;
    int unsigned     bps;
    if (mem_full_seen) return ST_OVERFLOW;
    if (fill_len < 12) return ST_SMALL;
    if (!has_id(0, ID_RIFF)) return ST_RIFF;
    if (!has_id(8, ID_WAVE)) return ST_WAVE;
    off = 12; d_off = 0; d_len = 0;
    t = 0; c = 0; r = 0; b = 0;
    got_fmt = 0; got_data = 0;
    while (off + 8 <= fill_len) begin
      size = mem_le(off + 4, 4);
      pay  = off + 8;
      if (has_id(off, ID_FMT)) begin
        if (size < 16 || pay + 16 > fill_len) return ST_FMT;
        t = 16'(mem_le(pay, 2));
        c = 16'(mem_le(pay + 2, 2));
        r = mem_le(pay + 4, 4);
        b = 16'(mem_le(pay + 14, 2));
        if (t == TAG_EXT) begin
          if (size < 40 || pay + 26 > fill_len) return ST_EXT;
          t = 16'(mem_le(pay + 24, 2));
        end
        got_fmt = 1;
      end else if (has_id(off, ID_DATA)) begin
        d_off    = pay;
        d_len    = (pay + size > fill_len) ? fill_len - pay : size;
        got_data = 1;
      end
      off += 8 + size + (size & 1);
    end
    if (!got_fmt) return ST_NOFMT;
    if (!got_data) return ST_NODATA;
    if (t != TAG_PCM && t != TAG_FLOAT) return ST_TAG;
    if (c == 0) return ST_CH;
    if (r == 0) return ST_RATE;
    bps = b / 8;
    if (bps == 0) return ST_DEPTH0;
    frm = d_len / (longint'(bps) * c);
    if (frm > 0) begin
      if (t == TAG_FLOAT && b != 32 && b != 64) return ST_FDEPTH;
      if (t == TAG_PCM && b != 8 && b != 16 && b != 24 && b != 32) return ST_PDEPTH;
    end
    held_tag    = t;
    held_ch     = c;
    held_rate   = r;
    held_bits   = b;
    held_start  = d_off;
    held_frames = (frm > 64'h1FFFF) ? 17'h1FFFF : 17'(frm);
    return ST_OK;
  endfunction

  // Magnitude m times 2^sh, truncated and saturated to signed Q0.31.
  function automatic longint q31_of_mag(longint unsigned m, int sh, bit neg);
    longint unsigned v;
    if (m == 0) return 0;
    if (sh >= 11) v = 64'h1_0000_0000;
    else if (sh >= 0) v = m << sh;
    else if (-sh < 64) v = m >> (-sh);
    else v = 0;
    if (neg) return (v >= 64'h8000_0000) ? -64'sd2147483648 : -longint'(v);
    return (v > 64'h7FFF_FFFF) ? 64'sd2147483647 : longint'(v);
  endfunction

  function automatic longint channel_q31(longint unsigned off);
    logic [63:0] w;
    logic [10:0] e;
    logic [15:0] h;
    logic [23:0] s24;
    logic [31:0] s32;
    w = {mem_le(off + 4, 4), mem_le(off, 4)};
    if (held_tag == TAG_FLOAT) begin
      if (held_bits == 64) begin
        e = w[62:52];
        if (e == 11'h7FF)
          return (w[51:0] != 0) ? 0 : (w[63] ? -64'sd2147483648 : 64'sd2147483647);
        return q31_of_mag((e != 0) ? {11'd1, w[51:0]} : {12'd0, w[51:0]},
                          ((e != 0) ? int'(e) : 1) - 1044, w[63]);
      end
      e = {3'd0, w[30:23]};
      if (e == 11'h0FF)
        return (w[22:0] != 0) ? 0 : (w[31] ? -64'sd2147483648 : 64'sd2147483647);
      return q31_of_mag((e != 0) ? {40'd1, w[22:0]} : {41'd0, w[22:0]},
                        ((e != 0) ? int'(e) : 1) - 119, w[31]);
    end
    case (held_bits)
      16'd8:   return (longint'(w[7:0]) - 128) * 16777216;
      16'd16:  begin h = w[15:0]; return longint'($signed(h)) * 65536; end
      16'd24:  begin s24 = w[23:0]; return longint'($signed(s24)) * 256; end
      default: begin s32 = w[31:0]; return longint'($signed(s32)); end
    endcase
  endfunction

  // Updates the predictor for one accepted request and queues its result.
  function automatic void predict(logic [1:0] op, logic [7:0] b, logic [15:0] idx);
    decode_result_t  r;
    longint          sum, q;
    longint unsigned base, bps;
    q = 0;
    case (op)
      OP_LOAD: begin
        if (fill_len < MEM_BYTES) begin
          file_mem[fill_len] = b;
          fill_len++;
        end else begin
          mem_full_seen = 1'b1;
        end
        drop_parse();
        return;
      end
      OP_CLEAR: begin
        fill_len      = 0;
        mem_full_seen = 1'b0;
        drop_parse();
        return;
      end
      OP_PARSE: begin
        drop_parse();
        r.status = walk_file();
        if (r.status != ST_OK) drop_parse();
        parse_held  = 1'b1;
        held_status = r.status;
      end
      default: begin
        if (parse_held && held_status != ST_OK) begin
          r.status = held_status;
        end else if (!parse_held || idx >= held_frames) begin
          r.status = ST_RANGE;
        end else begin
          bps  = held_bits / 8;
          base = held_start + longint'(idx) * bps * held_ch;
          sum  = 0;
          for (int c = 0; c < held_ch; c++) sum += channel_q31(base + c * bps);
          q = sum / (longint'(held_ch) * 256);
          if (q > 8388607) q = 8388607;
          if (q < -8388608) q = -8388608;
          r.status = ST_OK;
        end
      end
    endcase
    r.mono     = 24'(q);
    r.rate     = held_rate;
    r.frames   = held_frames;
    r.channels = held_ch;
    r.bits     = held_bits;
    pending_results.push_back(r);
  endfunction

  // ---------------------------------------------------------------- checking

  // Compares each accepted result with the oldest expectation.
  always @(posedge clk) begin
    decode_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: status %0d", status);
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status || mono_sample !== want.mono ||
            sample_rate !== want.rate || frame_count !== want.frames ||
            channel_count !== want.channels || bits_per_sample !== want.bits) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected st %0d mono %0d rate %0d fr %0d ch %0d bits %0d, got st %0d mono %0d rate %0d fr %0d ch %0d bits %0d",
                     want.status, want.mono, want.rate, want.frames, want.channels,
                     want.bits, status, mono_sample, sample_rate, frame_count,
                     channel_count, bits_per_sample);
        end
      end
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  // Sends one request and feeds it to the predictor once accepted.
  task automatic send_req(logic [1:0] op, logic [7:0] b = 8'd0, logic [15:0] idx = 16'd0);
    if (idle_on && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    opcode      <= op;
    data_byte   <= b;
    frame_index <= idx;
    do @(posedge clk); while (!in_ready);
    predict(op, b, idx);
  endtask

  // Holds the request side until every expected result has come.
  task automatic wait_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic void put_le(logic [31:0] v, int n);
    for (int k = 0; k < n; k++) wav_bytes.push_back(v[8*k +: 8]);
  endfunction

  function automatic void start_riff();
    wav_bytes.delete();
    put_le(ID_RIFF, 4);
    put_le($urandom, 4);
    put_le(ID_WAVE, 4);
  endfunction

  // A fmt chunk; a size of 26 or more carries the extensible sub-format tag.
  function automatic void put_fmt(logic [15:0] tag, logic [15:0] ch, logic [31:0] rate,
                                  logic [15:0] bits, int size = 16,
                                  logic [15:0] subtag = TAG_PCM);
    put_le(ID_FMT, 4);
    put_le(size, 4);
    put_le(tag, 2);
    put_le(ch, 2);
    put_le(rate, 4);
    put_le(rate * ch * bits / 8, 4);
    put_le(ch * bits / 8, 2);
    put_le(bits, 2);
    for (int k = 16; k < size; k++) begin
      if (k == 24) wav_bytes.push_back(subtag[7:0]);
      else if (k == 25) wav_bytes.push_back(subtag[15:8]);
      else wav_bytes.push_back(8'($urandom));
    end
    if (size % 2) wav_bytes.push_back(8'd0);
  endfunction

  // A chunk header with random payload and a pad byte after an odd payload.
  function automatic void put_chunk(logic [31:0] id, int n);
    put_le(id, 4);
    put_le(n, 4);
    for (int k = 0; k < n; k++) wav_bytes.push_back(8'($urandom));
    if (n % 2) wav_bytes.push_back(8'd0);
  endfunction

  task automatic load_file();
    send_req(OP_CLEAR);
    foreach (wav_bytes[i]) send_req(OP_LOAD, wav_bytes[i]);
  endtask

  task automatic load_parse_read(int reads);
    load_file();
    send_req(OP_PARSE);
    for (int i = 0; i < reads; i++) send_req(OP_READ, 8'd0, 16'(i));
  endtask

  // Requests before any file, and a file too short for a header.
  task automatic test_no_file();
    send_req(OP_READ, 8'd0, 16'd0);
    send_req(OP_PARSE);
    send_req(OP_READ, 8'd0, 16'd0);
    wav_bytes.delete();
    put_le(ID_RIFF, 4);
    put_le(32'd0, 4);
    put_le(ID_WAVE, 3);
    load_parse_read(1);
  endtask

  // Broken RIFF and WAVE tags, and a header with no chunks.
  task automatic test_header();
    start_riff();
    wav_bytes[3] = 8'h58;
    load_parse_read(1);
    start_riff();
    wav_bytes[11] = 8'h58;
    load_parse_read(1);
    start_riff();
    load_parse_read(1);
  endtask

  // Every PCM depth with one to three channels, reads at and past the end.
  task automatic test_pcm();
    logic [15:0] depths[4] = '{16'd8, 16'd16, 16'd24, 16'd32};
    foreach (depths[d]) begin
      for (int ch = 1; ch <= 3; ch++) begin
        start_riff();
        put_fmt(TAG_PCM, 16'(ch), 32'd44100, depths[d]);
        put_chunk(ID_DATA, 3 * ch * depths[d] / 8);
        load_parse_read(3);
        send_req(OP_READ, 8'd0, 16'd3);
        send_req(OP_READ, 8'd0, 16'hFFFF);
      end
    end
  endtask

  // Float samples: infinities, NaN, denormals, saturation and ordinary values.
  task automatic test_float();
    logic [31:0] words32[8] = '{32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 32'h3F80_0000,
                                32'hBF80_0000, 32'h0000_0001, 32'h3F00_0000, 32'hBE80_0001};
    logic [63:0] words64[8] = '{64'h3FF0_0000_0000_0000, 64'hBFD0_0000_0000_0000,
                                64'h7FF8_0000_0000_0000, 64'hFFF0_0000_0000_0000,
                                64'h7FF0_0000_0000_0000, 64'h7FF0_0000_0000_0000,
                                64'h0000_0000_0000_0001, 64'h3E00_0000_0000_0003};
    start_riff();
    put_fmt(TAG_FLOAT, 16'd1, 32'd48000, 16'd32);
    put_le(ID_DATA, 4);
    put_le(32, 4);
    foreach (words32[i]) put_le(words32[i], 4);
    load_parse_read(8);
    start_riff();
    put_fmt(TAG_EXT, 16'd2, 32'd96000, 16'd64, 40, TAG_FLOAT);
    put_le(ID_DATA, 4);
    put_le(64, 4);
    foreach (words64[i]) begin
      put_le(words64[i][31:0], 4);
      put_le(words64[i][63:32], 4);
    end
    load_parse_read(4);
  endtask

  // Each error of the chunk walk and the format checks in turn, plus layouts that still parse.
  task automatic test_parse_errors();
    start_riff(); put_fmt(TAG_PCM, 1, 8000, 16, 14); put_chunk(ID_DATA, 4);
    load_parse_read(1);
    start_riff(); put_chunk(ID_DATA, 4); put_le(ID_FMT, 4); put_le(16, 4); put_le(1, 4);
    load_parse_read(1);
    start_riff(); put_fmt(TAG_EXT, 1, 8000, 16, 30); put_chunk(ID_DATA, 4);
    load_parse_read(1);
    start_riff(); put_chunk(ID_DATA, 4); put_fmt(TAG_EXT, 1, 8000, 16, 40, TAG_PCM);
    wav_bytes = wav_bytes[0:wav_bytes.size() - 24];
    load_parse_read(1);
    start_riff(); put_chunk(ID_DATA, 4);
    load_parse_read(1);
    start_riff(); put_fmt(TAG_PCM, 1, 8000, 16);
    load_parse_read(1);
    start_riff(); put_fmt(16'd2, 1, 8000, 16); put_chunk(ID_DATA, 4);
    load_parse_read(1);
    start_riff(); put_fmt(TAG_PCM, 0, 8000, 16); put_chunk(ID_DATA, 4);
    load_parse_read(1);
    start_riff(); put_fmt(TAG_PCM, 1, 0, 16); put_chunk(ID_DATA, 4);
    load_parse_read(1);
    start_riff(); put_fmt(TAG_PCM, 1, 8000, 7); put_chunk(ID_DATA, 4);
    load_parse_read(1);
    start_riff(); put_fmt(TAG_FLOAT, 1, 8000, 16); put_chunk(ID_DATA, 4);
    load_parse_read(1);
    start_riff(); put_fmt(TAG_PCM, 1, 8000, 12); put_chunk(ID_DATA, 4);
    load_parse_read(1);
    // An odd depth with one whole frame of data is still rejected.
    start_riff(); put_fmt(TAG_PCM, 2, 8000, 12); put_chunk(ID_DATA, 3);
    load_parse_read(1);
    // Data first, a padded odd chunk, two fmt chunks, a data size past the file end.
    start_riff(); put_chunk(ID_DATA, 2); put_chunk(32'h6B6E_756A, 5);
    put_fmt(TAG_FLOAT, 1, 8000, 32); put_fmt(TAG_PCM, 2, 22050, 16);
    put_le(ID_DATA, 4); put_le(32'hFFFF_FFF0, 4);
    for (int k = 0; k < 9; k++) wav_bytes.push_back(8'($urandom));
    load_parse_read(3);
    // A parse result is dropped by the next load.
    send_req(OP_LOAD, 8'hA5);
    send_req(OP_READ, 8'd0, 16'd0);
  endtask

  // Fills the memory with one long 8 bit file, then overflows it.
  task automatic test_overflow();
    idle_on  = 1'b0;
    stall_on = 1'b0;
    start_riff();
    put_fmt(TAG_PCM, 1, 32'hFFFF_FFFF, 8);
    put_le(ID_DATA, 4);
    put_le(MEM_BYTES - 44, 4);
    load_file();
    for (int k = 44; k < MEM_BYTES; k++) send_req(OP_LOAD, 8'($urandom));
    send_req(OP_PARSE);
    send_req(OP_READ, 8'd0, 16'(MEM_BYTES - 45));
    send_req(OP_READ, 8'd0, 16'(MEM_BYTES - 44));
    send_req(OP_READ, 8'd0, 16'hFFFF);
    for (int i = 0; i < 6; i++) send_req(OP_READ, 8'd0, 16'($urandom_range(0, MEM_BYTES - 45)));
    send_req(OP_LOAD, 8'h5A);
    send_req(OP_PARSE);
    send_req(OP_READ, 8'd0, 16'd0);
    send_req(OP_CLEAR);
    send_req(OP_PARSE);
    idle_on  = 1'b1;
    stall_on = 1'b1;
  endtask

  // Mostly well-formed random files, some damaged, with random reads and stray requests.
  task automatic test_random();
    logic [15:0] tag, sub, bits, ch;
    logic [31:0] rate;
    int          pick, frames, bps, fsize;
    for (int n = 0; n < 14; n++) begin
      pick = $urandom_range(9);
      sub  = (pick < 7) ? TAG_PCM : TAG_FLOAT;
      tag  = (pick >= 5 && pick < 7) ? TAG_EXT : sub;
      if (tag == TAG_EXT) sub = ($urandom_range(1)) ? TAG_PCM : TAG_FLOAT;
      if (sub == TAG_FLOAT) bits = ($urandom_range(1)) ? 16'd32 : 16'd64;
      else bits = 16'(8 * $urandom_range(1, 4));
      if ($urandom_range(9) == 0) bits = 16'($urandom_range(0, 40));
      ch    = 16'($urandom_range(1, 4));
      rate  = ($urandom_range(19) == 0) ? 32'd0 : $urandom;
      fsize = (tag == TAG_EXT) ? 40 : 16;
      bps   = (bits / 8 == 0) ? 1 : bits / 8;
      frames = $urandom_range(0, 4);
      start_riff();
      if ($urandom_range(2) == 0) put_chunk($urandom, $urandom_range(0, 5));
      if ($urandom_range(3) == 0) begin
        put_chunk(ID_DATA, frames * ch * bps + $urandom_range(0, 1));
        put_fmt(tag, ch, rate, bits, fsize, sub);
      end else begin
        put_fmt(tag, ch, rate, bits, fsize, sub);
        put_chunk(ID_DATA, frames * ch * bps + $urandom_range(0, 1));
      end
      if ($urandom_range(5) == 0)
        wav_bytes = wav_bytes[0:wav_bytes.size() - 1 - $urandom_range(1, 10)];
      if ($urandom_range(7) == 0)
        wav_bytes[$urandom_range(0, wav_bytes.size() - 1)] = 8'($urandom);
      load_file();
      send_req(OP_PARSE);
      for (int i = 0; i < 5; i++) begin
        if ($urandom_range(4) == 0) send_req(OP_READ, 8'd0, 16'($urandom));
        else send_req(OP_READ, 8'd0, 16'($urandom_range(0, 4)));
      end
      if ($urandom_range(3) == 0) send_req(2'($urandom), 8'($urandom), 16'($urandom));
      if (n == 6) wait_results();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_no_file();
    test_header();
    test_pcm();
    test_float();
    wait_results();
    test_parse_errors();
    test_overflow();
    test_random();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
